@@ rtl/gis_pkg.sv @@
// shared types and constants for the graph infection spread step block
// no dependencies; used by gis_bitmem, gis_count and graph_infection_spread_step
package gis_pkg;

  // node space and field widths
  localparam int NODES_DEF = 65536;
  localparam int NODE_W    = 16;
  localparam int PCT_W     = 7;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 1;

  // bit stores are organized in rows of ROW_BITS nodes
  localparam int ROW_BITS = 8;
  localparam int BIT_W    = $clog2(ROW_BITS);

  // register reset values
  localparam logic [PCT_W-1:0] SEED_RESET   = 7'd1;
  localparam logic [PCT_W-1:0] SPREAD_RESET = 7'd3;

  // item modes
  localparam logic [1:0] MODE_SEED  = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_ROUND = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 1'd1;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE1,
    S_EDGE2,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  // masked row write request
  typedef struct packed {
    logic                en;
    logic [ROW_BITS-1:0] mask;
    logic [ROW_BITS-1:0] data;
  } wr_t;

  // one-hot mask for a bit inside a row
  function automatic logic [ROW_BITS-1:0] bit_mask(input logic [BIT_W-1:0] b);
    return ROW_BITS'(1) << b;
  endfunction

endpackage

@@ rtl/gis_bitmem.sv @@
// row-organized bit store: one masked write port, one registered read port
// depends on gis_pkg for the row width and the write request struct
module gis_bitmem import gis_pkg::*; #(
  parameter int ROWS   = NODES_DEF / ROW_BITS,
  parameter int ROW_AW = 13
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ROW_AW-1:0]   rd_addr,
  output logic [ROW_BITS-1:0] rd_data,
  input  wr_t                 wr,
  input  logic [ROW_AW-1:0]   wr_addr
);

  logic [ROW_BITS-1:0] mem [ROWS];

  // masked write, bit by bit
  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < ROW_BITS; i++) begin
        if (wr.mask[i]) begin
          mem[wr_addr][i] <= wr.data[i];
        end
      end
    end
  end

  // read data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/gis_count.sv @@
// saturating infected-node counter fed one row of bits per cycle while add_en is high
// depends on gis_pkg for the row and count widths
module gis_count import gis_pkg::*; (
  input  logic                clk,
  input  logic                clr,
  input  logic                add_en,
  input  logic [ROW_BITS-1:0] row,
  output logic [CNT_W-1:0]    count
);

  logic [BIT_W:0]   pop;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] count_next;

  // population count of the row and saturating add
  always_comb begin
    pop = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      pop = pop + (BIT_W+1)'(row[i]);
    end
    sum = {1'b0, count} + (CNT_W+1)'(pop);
    count_next = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      count <= '0;
    end else if (add_en) begin
      count <= count_next;
    end
  end

endmodule

@@ rtl/graph_infection_spread_step.sv @@
// top level of the graph infection spread step block
// depends on gis_pkg, gis_bitmem and gis_count
//
// usage: items enter on in_valid/in_ready with mode, node_a, node_b, roll_a,
// roll_b. a seed item marks node_a infected when roll_a < seed_percent. an edge
// item reads both endpoints in the current store and marks the other endpoint
// in the next store when the infected side rolls below spread_percent. an
// end-of-round item yields one infected_count on out_valid/out_ready, then
// merges next into current and clears next. registers are written on
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data.
// structure: both stores are rows of ROW_BITS nodes in single-read-port memories.
// a seed item is written in the cycle it is accepted; an edge item makes one
// current-store read and one next-store write per endpoint; an end-of-round
// item sweeps all ROWS = ceil(NODES / ROW_BITS) rows one row a cycle to count
// and merge. the count sits in an output register; new items are taken
// while it waits, and a later round holds in its last state until the
// receiver takes the earlier count.
// reset: a clearing pass writes zero to every row of both stores with in_ready
// low; configuration writes are taken throughout.
module graph_infection_spread_step import gis_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [NODE_W-1:0]    node_a,
  input  logic [NODE_W-1:0]    node_b,
  input  logic [PCT_W-1:0]     roll_a,
  input  logic [PCT_W-1:0]     roll_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CNT_W-1:0]     infected_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data
);

  localparam int ROWS   = (NODES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  // node helpers
  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return (n != '0) && (32'(n) < 32'(NODES));
  endfunction

  function automatic logic [ROW_AW-1:0] row_of(input logic [NODE_W-1:0] n);
    logic [31:0] ext;
    ext = 32'(n);
    return ext[BIT_W +: ROW_AW];
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [NODE_W-1:0] n);
    return n[BIT_W-1:0];
  endfunction

  state_t              state, state_next;
  logic [ROW_AW-1:0]   row_cnt, row_cnt_next;
  logic                wr_pend;
  logic [ROW_AW-1:0]   wr_row;
  logic [PCT_W-1:0]    seed_percent, spread_percent;
  logic                accept;

  // edge item registers
  logic [ROW_AW-1:0]   a_row, b_row;
  logic [BIT_W-1:0]    a_bit, b_bit;
  logic                a_ok, b_ok, hit_a, hit_b;

  // memory ports
  logic                now_rd_en, next_rd_en;
  logic [ROW_AW-1:0]   now_rd_addr, next_rd_addr, now_wr_addr, next_wr_addr;
  logic [ROW_BITS-1:0] now_q, next_q;
  wr_t                 now_wr, next_wr;

  // counter and output control
  logic                cnt_clr, cnt_add, out_load;
  logic [CNT_W-1:0]    count;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  gis_bitmem #(.ROWS(ROWS), .ROW_AW(ROW_AW)) u_now (
    .clk     (clk),
    .rd_en   (now_rd_en),
    .rd_addr (now_rd_addr),
    .rd_data (now_q),
    .wr      (now_wr),
    .wr_addr (now_wr_addr)
  );

  gis_bitmem #(.ROWS(ROWS), .ROW_AW(ROW_AW)) u_next (
    .clk     (clk),
    .rd_en   (next_rd_en),
    .rd_addr (next_rd_addr),
    .rd_data (next_q),
    .wr      (next_wr),
    .wr_addr (next_wr_addr)
  );

  gis_count u_count (
    .clk    (clk),
    .clr    (cnt_clr),
    .add_en (cnt_add),
    .row    (now_q),
    .count  (count)
  );

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      row_cnt <= '0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      row_cnt <= row_cnt_next;
      wr_pend <= (state == S_SWEEP);
    end
  end

  // row being written back: the row read in the cycle before
  always_ff @(posedge clk) begin
    wr_row <= row_cnt;
  end

  // next state, memory ports and counter control
  always_comb begin
    state_next   = state;
    row_cnt_next = row_cnt;
    now_rd_en    = 1'b0;
    now_rd_addr  = row_cnt;
    next_rd_en   = 1'b0;
    next_rd_addr = row_cnt;
    now_wr       = '0;
    now_wr_addr  = row_cnt;
    next_wr      = '0;
    next_wr_addr = row_cnt;
    cnt_clr      = 1'b0;
    cnt_add      = 1'b0;
    out_load     = 1'b0;
    case (state)
      S_CLEAR: begin
        now_wr  = '{en: 1'b1, mask: '1, data: '0};
        next_wr = '{en: 1'b1, mask: '1, data: '0};
        if (row_cnt == LAST_ROW) begin
          row_cnt_next = '0;
          state_next   = S_IDLE;
        end else begin
          row_cnt_next = row_cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_SEED: begin
              now_wr.en   = (roll_a < seed_percent) && node_ok(node_a);
              now_wr.mask = bit_mask(bit_of(node_a));
              now_wr.data = '1;
              now_wr_addr = row_of(node_a);
            end
            MODE_EDGE: begin
              now_rd_en   = 1'b1;
              now_rd_addr = row_of(node_a);
              state_next  = S_EDGE1;
            end
            MODE_ROUND: begin
              cnt_clr      = 1'b1;
              row_cnt_next = '0;
              state_next   = S_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      S_EDGE1: begin
        // node_a row is back: spread a to b, fetch node_b row
        next_wr.en   = a_ok && now_q[a_bit] && hit_a && b_ok;
        next_wr.mask = bit_mask(b_bit);
        next_wr.data = '1;
        next_wr_addr = b_row;
        now_rd_en    = 1'b1;
        now_rd_addr  = b_row;
        state_next   = S_EDGE2;
      end
      S_EDGE2: begin
        // node_b row is back: spread b to a
        next_wr.en   = b_ok && now_q[b_bit] && hit_b && a_ok;
        next_wr.mask = bit_mask(a_bit);
        next_wr.data = '1;
        next_wr_addr = a_row;
        state_next   = S_IDLE;
      end
      S_SWEEP: begin
        now_rd_en  = 1'b1;
        next_rd_en = 1'b1;
        if (wr_pend) begin
          now_wr       = '{en: 1'b1, mask: '1, data: now_q | next_q};
          now_wr_addr  = wr_row;
          next_wr      = '{en: 1'b1, mask: '1, data: '0};
          next_wr_addr = wr_row;
          cnt_add      = 1'b1;
        end
        if (row_cnt == LAST_ROW) begin
          state_next = S_DRAIN;
        end else begin
          row_cnt_next = row_cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        // last row of the sweep
        now_wr       = '{en: 1'b1, mask: '1, data: now_q | next_q};
        now_wr_addr  = wr_row;
        next_wr      = '{en: 1'b1, mask: '1, data: '0};
        next_wr_addr = wr_row;
        cnt_add      = 1'b1;
        row_cnt_next = '0;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // edge item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      a_row <= row_of(node_a);
      b_row <= row_of(node_b);
      a_bit <= bit_of(node_a);
      b_bit <= bit_of(node_b);
      a_ok  <= node_ok(node_a);
      b_ok  <= node_ok(node_b);
      hit_a <= (roll_a < spread_percent);
      hit_b <= (roll_b < spread_percent);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_percent   <= SEED_RESET;
      spread_percent <= SPREAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEED:   seed_percent   <= cfg_data;
        REG_SPREAD: spread_percent <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      infected_count <= count;
    end
  end

  // sweep write-back never lands on the row being read
  a_sweep_rows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && wr_pend) |-> (wr_row != row_cnt))
    else $error("sweep write-back collides with read row");

  // an accepted edge item goes on to its first read-back state
  a_edge_seq: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_EDGE) |=> (state == S_EDGE1))
    else $error("edge item did not enter its read sequence");

  // a current-store write from idle comes only from an accepted seed item
  a_seed_write: assert property (@(posedge clk) disable iff (rst)
    (now_wr.en && state == S_IDLE) |-> (accept && mode == MODE_SEED))
    else $error("current store written from idle without a seed item");

  // a count is loaded only when the output register is free or being taken
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("count overwrote an untaken result");

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for graph_infection_spread_step: seeds, edges and round ends
// are driven on valid/ready and each infected_count is checked against a local predictor
// depends on gis_pkg and the graph_infection_spread_step rtl
module testbench;
  import gis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int ROWS          = (NODES_DEF + ROW_BITS - 1) / ROW_BITS;
  localparam int HOLD_CYCLES   = 3 * ROWS;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 210;
  localparam longint LIMIT_CYCLES = 4 * (2000 * (ROWS + 24) + ROWS + HOLD_CYCLES);

  // the one mode value without a package name; the block drops it
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [PCT_W-1:0]  ra;
    logic [PCT_W-1:0]  rb;
  } item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode = MODE_SEED;
  logic [NODE_W-1:0]    node_a = '0;
  logic [NODE_W-1:0]    node_b = '0;
  logic [PCT_W-1:0]     roll_a = '0;
  logic [PCT_W-1:0]     roll_b = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CNT_W-1:0]     infected_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEED;
  logic [PCT_W-1:0]     cfg_data = '0;

  // handshake flags registered at the rising edge, read at the falling edge
  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;

  // stimulus and idling controls
  item_t pending[$];
  int    sender_idle = 11;
  int    recv_idle   = 47;
  int    holds_asked = 0;
  int    holds_granted = 0;
  int    hold_left = 0;
  int    errors = 0;

  // predicted block state
  bit                sick_now [NODES_DEF];
  bit                sick_next [NODES_DEF];
  int                now_total = 0;
  int                next_nodes[$];
  logic [PCT_W-1:0]  seed_pct = SEED_RESET;
  logic [PCT_W-1:0]  spread_pct = SPREAD_RESET;
  logic [CNT_W-1:0]  counts_due[$];

  graph_infection_spread_step dut (.*);

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  task automatic report(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // node 0 is never marked
  function automatic void infect_now(input int n);
    if (n != 0 && !sick_now[n]) begin
      sick_now[n] = 1'b1;
      now_total++;
    end
  endfunction

  function automatic void infect_next(input int n);
    if (n != 0 && !sick_next[n]) begin
      sick_next[n] = 1'b1;
      next_nodes.push_back(n);
    end
  endfunction

  // advance the predicted stores by one accepted item
  function automatic void advance_infection(input item_t it);
    bit hit_a;
    bit hit_b;
    case (it.op)
      MODE_SEED: begin
        if (it.ra < seed_pct) infect_now(int'(it.a));
      end
      MODE_EDGE: begin
        hit_a = (it.a != 0) && sick_now[it.a];
        hit_b = (it.b != 0) && sick_now[it.b];
        if (hit_a && it.ra < spread_pct) infect_next(int'(it.b));
        if (hit_b && it.rb < spread_pct) infect_next(int'(it.a));
      end
      MODE_ROUND: begin
        counts_due.push_back((now_total > 65535) ? 16'hFFFF : CNT_W'(now_total));
        foreach (next_nodes[i]) begin
          infect_now(next_nodes[i]);
          sick_next[next_nodes[i]] = 1'b0;
        end
        next_nodes.delete();
      end
      default: ;
    endcase
  endfunction

  // monitor: predict on accepted items, check accepted counts, track register writes
  always @(posedge clk) begin : watch_ports
    logic [CNT_W-1:0] want;
    in_fire  <= !rst && in_valid && in_ready;
    cfg_fire <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (counts_due.size() == 0) begin
          report($sformatf("infected_count %0d with none expected", infected_count));
        end else begin
          want = counts_due.pop_front();
          if (infected_count !== want)
            report($sformatf("infected_count %0d, expected %0d", infected_count, want));
        end
      end
      if (in_valid && in_ready)
        advance_infection('{op: mode, a: node_a, b: node_b, ra: roll_a, rb: roll_b});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SEED) seed_pct = cfg_data;
        else if (cfg_index == REG_SPREAD) spread_pct = cfg_data;
      end
    end
  end

  // driver: next item from the queue, with random gaps
  always @(negedge clk) begin : drive_items
    item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending.size() != 0 && $urandom_range(99) >= sender_idle) begin
        nxt = pending.pop_front();
        in_valid <= 1'b1;
        mode     <= nxt.op;
        node_a   <= nxt.a;
        node_b   <= nxt.b;
        roll_a   <= nxt.ra;
        roll_b   <= nxt.rb;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      hold_left     <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end
  end

  // receiver readiness
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t make_item(input logic [1:0] op, input logic [NODE_W-1:0] a,
                                      input logic [NODE_W-1:0] b, input logic [PCT_W-1:0] ra,
                                      input logic [PCT_W-1:0] rb);
    item_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    it.ra = ra;
    it.rb = rb;
    return it;
  endfunction

  // mostly a small pool so that infection spreads, sometimes node 0, the top or anywhere
  function automatic logic [NODE_W-1:0] pick_node();
    int r;
    r = $urandom_range(99);
    if (r < 80) return NODE_W'($urandom_range(1, 48));
    if (r < 85) return '0;
    if (r < 90) return NODE_W'(65535 - $urandom_range(15));
    return NODE_W'($urandom);
  endfunction

  function automatic logic [PCT_W-1:0] pick_roll();
    if ($urandom_range(99) < 92) return PCT_W'($urandom_range(99));
    return PCT_W'($urandom_range(100, 127));
  endfunction

  // well-formed rounds with random content, plus dropped items and odd round ends
  task automatic build_rounds(input int quota);
    int added;
    added = 0;
    while (added < quota) begin
      repeat ($urandom_range(1, 8)) begin
        pending.push_back(make_item(MODE_SEED, pick_node(), NODE_W'($urandom),
                                    pick_roll(), pick_roll()));
        added++;
      end
      repeat ($urandom_range(10, 50)) begin
        if ($urandom_range(99) < 4)
          pending.push_back(make_item(MODE_IGNORED, NODE_W'($urandom), NODE_W'($urandom),
                                      PCT_W'($urandom), PCT_W'($urandom)));
        pending.push_back(make_item(MODE_EDGE, pick_node(), pick_node(),
                                    pick_roll(), pick_roll()));
        added++;
      end
      if ($urandom_range(99) < 90) begin
        pending.push_back(make_item(MODE_ROUND, NODE_W'($urandom), NODE_W'($urandom),
                                    PCT_W'($urandom), PCT_W'($urandom)));
        added++;
      end
      if ($urandom_range(99) < 8) begin
        pending.push_back(make_item(MODE_ROUND, pick_node(), pick_node(),
                                    pick_roll(), pick_roll()));
        added++;
      end
    end
  endtask

  // directed items at the reset percents: seed 1, spread 3
  task automatic load_directed();
    pending.push_back(make_item(MODE_SEED, 16'd1, 16'd0, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_SEED, 16'd2, 16'hFFFF, 7'd1, 7'd0));
    pending.push_back(make_item(MODE_SEED, 16'd0, 16'd0, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_SEED, 16'hFFFF, 16'd3, 7'd0, 7'd127));
    pending.push_back(make_item(MODE_SEED, 16'd1, 16'd0, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_SEED, 16'd3, 16'd0, 7'd127, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd1, 16'd5, 7'd2, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd6, 16'hFFFF, 7'd99, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd1, 16'd1, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd0, 16'd1, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd7, 16'd8, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd1, 16'd9, 7'd3, 7'd0));
    pending.push_back(make_item(MODE_EDGE, 16'd2, 16'hFFFF, 7'd0, 7'd100));
    pending.push_back(make_item(MODE_EDGE, 16'd1, 16'd10, 7'd127, 7'd127));
    pending.push_back(make_item(MODE_ROUND, 16'd0, 16'd0, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_IGNORED, 16'd4, 16'd4, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_ROUND, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127));
    pending.push_back(make_item(MODE_EDGE, 16'd5, 16'd11, 7'd0, 7'd99));
    pending.push_back(make_item(MODE_SEED, 16'd12, 16'd0, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_SEED, 16'h8000, 16'h7FFF, 7'h40, 7'h3F));
    pending.push_back(make_item(MODE_ROUND, 16'd0, 16'd0, 7'd0, 7'd0));
    pending.push_back(make_item(MODE_ROUND, 16'd0, 16'd0, 7'd0, 7'd0));
  endtask

  // wait until every item is taken and every count returned, then let the block settle
  task automatic wait_drained();
    do @(negedge clk); while (pending.size() != 0 || in_valid || counts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // reset, directed part, then random phases under changing percents and idling
  initial begin : stimulus
    logic [PCT_W-1:0] seed_v;
    logic [PCT_W-1:0] spread_v;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_directed();
    wait_drained();
    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      case (p)
        1: begin seed_v = 7'd100; spread_v = 7'd100; end
        2: begin seed_v = 7'd0;   spread_v = 7'd0;   end
        3: begin seed_v = 7'd127; spread_v = 7'd127; end
        6: begin seed_v = 7'd30;  spread_v = 7'd60;  end
        default: begin
          seed_v   = PCT_W'($urandom_range(100));
          spread_v = PCT_W'($urandom_range(100));
        end
      endcase
      write_reg(REG_SEED, seed_v);
      write_reg(REG_SPREAD, spread_v);
      @(posedge clk);
      if (p < 3) begin
        sender_idle = 11;
        recv_idle   = 47;
      end else if (p < 6) begin
        sender_idle = 47;
        recv_idle   = 11;
      end else begin
        sender_idle = 0;
        recv_idle   = 0;
      end
      if (p == 3) holds_asked++;
      build_rounds(PHASE_ITEMS);
      wait_drained();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
